FILE: src/tppmm_pkg.sv
package tppmm_pkg;

  // image and plane geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int POS_W      = 8;
  localparam int CFG_W      = 9;
  localparam int PLANE_BITS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W      = $clog2(PLANE_BITS);
  localparam int WORD_W     = 32;
  localparam int OFS_W      = $clog2(WORD_W);
  localparam int WORDS      = PLANE_BITS / WORD_W;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int SUM_W      = POS_W + CFG_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // neighbour slots visited by a query, center first
  localparam int NB_W = 3;
  localparam logic [NB_W-1:0] NB_CENTER = 3'd0;
  localparam logic [NB_W-1:0] NB_LEFT   = 3'd1;
  localparam logic [NB_W-1:0] NB_UP     = 3'd2;
  localparam logic [NB_W-1:0] NB_RIGHT  = 3'd3;
  localparam logic [NB_W-1:0] NB_DOWN   = 3'd4;

  // item operations
  typedef enum logic [1:0] {
    OP_WR_FOUND = 2'd0,
    OP_WR_OVL   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_MERGE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_DISPATCH,
    ST_WR_READ,
    ST_WR_WRITE,
    ST_Q_READ,
    ST_Q_CAP,
    ST_MG_READ,
    ST_MG_WRITE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic clr_wr;
    logic rd_point;
    logic wr_point;
    logic rd_sweep;
    logic wr_merge;
    logic cap_nb;
    logic nb_inc;
    logic cnt_inc;
    logic flag_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic in_img;
    logic cnt_last;
    logic nb_last;
  } sts_t;

endpackage

FILE: src/two_plane_pixel_mark_map_core.sv
// Two one-bit planes (found, overlapped) over an image of up to 256 x 256 points.
// Input: an item is taken when start is high and busy is low; op selects
// write found bit, write overlapped bit, query point, or merge found into
// overlapped. pos_x/pos_y address the point, mark_value is the bit written.
// Output: one result per item, held on status and the bit/mask ports while
// done is high for a single cycle; the receiver has no way to stall it.
// Configuration: cfg_we/cfg_index/cfg_data write image_width (index 0) or
// image_height (index 1); other indexes are ignored. The user must write them
// only while the block is idle; the block itself does not enforce it.
// Out-of-range writes and queries go through index and dispatch to done;
// writes read the point's word and write it back; queries make five reads
// of the point and its neighbours, one 32-bit word per plane per read; merge
// reads and writes back every plane word. One item at a time; busy stays
// high until the cycle after done, so the next transfer can come in the
// cycle after the result. Reset: both planes sit in 2048-word memories
// that are cleared by a sweep after rst; busy is high during that sweep.
module two_plane_pixel_mark_map_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  output logic                            done,
  input  logic [1:0]                      op,
  input  logic [tppmm_pkg::POS_W-1:0]     pos_x,
  input  logic [tppmm_pkg::POS_W-1:0]     pos_y,
  input  logic                            mark_value,
  input  logic                            cfg_we,
  input  logic [tppmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tppmm_pkg::CFG_W-1:0]     cfg_data,
  output logic                            status,
  output logic                            found_bit,
  output logic                            overlapped_bit,
  output logic [3:0]                      found_neighbour_mask,
  output logic [3:0]                      overlapped_neighbour_mask
);
  import tppmm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tppmm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  // planes, index arithmetic and result registers
  tppmm_dp u_dp (
    .clk                       (clk),
    .rst                       (rst),
    .cmd                       (cmd),
    .sts                       (sts),
    .op                        (op),
    .pos_x                     (pos_x),
    .pos_y                     (pos_y),
    .mark_value                (mark_value),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .status                    (status),
    .found_bit                 (found_bit),
    .overlapped_bit            (overlapped_bit),
    .found_neighbour_mask      (found_neighbour_mask),
    .overlapped_neighbour_mask (overlapped_neighbour_mask)
  );

endmodule

FILE: src/tppmm_dp.sv
module tppmm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tppmm_pkg::cmd_t               cmd,
  output tppmm_pkg::sts_t               sts,
  input  logic [1:0]                    op,
  input  logic [tppmm_pkg::POS_W-1:0]   pos_x,
  input  logic [tppmm_pkg::POS_W-1:0]   pos_y,
  input  logic                          mark_value,
  input  logic                          cfg_we,
  input  logic [tppmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tppmm_pkg::CFG_W-1:0]   cfg_data,
  output logic                          status,
  output logic                          found_bit,
  output logic                          overlapped_bit,
  output logic [3:0]                    found_neighbour_mask,
  output logic [3:0]                    overlapped_neighbour_mask
);
  import tppmm_pkg::*;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [CFG_W-1:0]  eff_w;
  logic [CFG_W-1:0]  eff_h;
  op_t               op_r;
  logic [POS_W-1:0]  x_r;
  logic [POS_W-1:0]  y_r;
  logic              mv_r;
  logic [IDX_W-1:0]  idx;
  logic              in_img;
  logic [SUM_W-1:0]  idx_sum;
  logic [IDX_W-1:0]  nb_idx;
  logic [NB_W-1:0]   nb_cnt;
  logic [ADDR_W-1:0] cnt;
  logic [OFS_W-1:0]  rd_bit;
  logic              v_left;
  logic              v_up;
  logic              v_right;
  logic              v_down;
  logic [WORD_W-1:0] found_mem [WORDS];
  logic [WORD_W-1:0] ovl_mem [WORDS];
  logic [WORD_W-1:0] f_q;
  logic [WORD_W-1:0] o_q;
  logic [WORD_W-1:0] pt_word;
  logic [WORD_W-1:0] wr_word;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_re;
  logic              f_we;
  logic              o_we;
  logic [WORD_W-1:0] f_wd;
  logic [WORD_W-1:0] o_wd;
  logic              f_bit;
  logic              o_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(MAX_WIDTH);
      image_height <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp size to the plane dimensions
  assign eff_w = (image_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : image_width;
  assign eff_h = (image_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : image_height;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(op);
      x_r  <= pos_x;
      y_r  <= pos_y;
      mv_r <= mark_value;
    end
  end

  // linear index and range check
  assign idx_sum = y_r * eff_w + SUM_W'(x_r);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      idx    <= IDX_W'(idx_sum);
      in_img <= (CFG_W'(x_r) < eff_w) && (CFG_W'(y_r) < eff_h);
    end
  end

  // neighbour validity
  assign v_left  = (x_r != '0);
  assign v_up    = (y_r != '0);
  assign v_right = (CFG_W'(x_r) + CFG_W'(1)) < eff_w;
  assign v_down  = (CFG_W'(y_r) + CFG_W'(1)) < eff_h;

  // neighbour slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      nb_cnt <= NB_CENTER;
    end else if (cmd.load) begin
      nb_cnt <= NB_CENTER;
    end else if (cmd.nb_inc) begin
      nb_cnt <= nb_cnt + NB_W'(1);
    end
  end

  // address of the current slot
  always_comb begin
    case (nb_cnt)
      NB_LEFT:  nb_idx = idx - IDX_W'(1);
      NB_UP:    nb_idx = idx - IDX_W'(eff_w);
      NB_RIGHT: nb_idx = idx + IDX_W'(1);
      NB_DOWN:  nb_idx = idx + IDX_W'(eff_w);
      default:  nb_idx = idx;
    endcase
  end

  // sweep counter for clearing and merging, wraps after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_point) begin
      rd_bit <= nb_idx[OFS_W-1:0];
    end
  end

  // memory port control
  assign mem_addr = (cmd.clr_wr || cmd.rd_sweep || cmd.wr_merge) ? cnt
                                                                 : nb_idx[IDX_W-1:OFS_W];
  assign mem_re   = cmd.rd_point || cmd.rd_sweep;

  always_comb begin
    pt_word = (op_r == OP_WR_FOUND) ? f_q : o_q;
    wr_word = pt_word;
    wr_word[rd_bit] = mv_r;
  end

  assign f_we = cmd.clr_wr || (cmd.wr_point && op_r == OP_WR_FOUND);
  assign o_we = cmd.clr_wr || (cmd.wr_point && op_r == OP_WR_OVL) || cmd.wr_merge;
  assign f_wd = cmd.clr_wr ? '0 : wr_word;
  assign o_wd = cmd.clr_wr ? '0 : (cmd.wr_merge ? (f_q | o_q) : wr_word);

  // found plane
  always_ff @(posedge clk) begin
    if (f_we) begin
      found_mem[mem_addr] <= f_wd;
    end
    if (mem_re) begin
      f_q <= found_mem[mem_addr];
    end
  end

  // overlapped plane
  always_ff @(posedge clk) begin
    if (o_we) begin
      ovl_mem[mem_addr] <= o_wd;
    end
    if (mem_re) begin
      o_q <= ovl_mem[mem_addr];
    end
  end

  assign f_bit = f_q[rd_bit];
  assign o_bit = o_q[rd_bit];

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status                    <= 1'b0;
      found_bit                 <= 1'b0;
      overlapped_bit            <= 1'b0;
      found_neighbour_mask      <= '0;
      overlapped_neighbour_mask <= '0;
    end else begin
      if (cmd.flag_err) begin
        status <= 1'b1;
      end
      if (cmd.cap_nb) begin
        case (nb_cnt)
          NB_CENTER: begin
            found_bit      <= f_bit;
            overlapped_bit <= o_bit;
          end
          NB_LEFT: begin
            found_neighbour_mask[0]      <= f_bit & v_left;
            overlapped_neighbour_mask[0] <= o_bit & v_left;
          end
          NB_UP: begin
            found_neighbour_mask[1]      <= f_bit & v_up;
            overlapped_neighbour_mask[1] <= o_bit & v_up;
          end
          NB_RIGHT: begin
            found_neighbour_mask[2]      <= f_bit & v_right;
            overlapped_neighbour_mask[2] <= o_bit & v_right;
          end
          NB_DOWN: begin
            found_neighbour_mask[3]      <= f_bit & v_down;
            overlapped_neighbour_mask[3] <= o_bit & v_down;
          end
          default: ;
        endcase
      end
    end
  end

  // status back to the controller
  assign sts.op       = op_r;
  assign sts.in_img   = in_img;
  assign sts.cnt_last = (cnt == ADDR_W'(WORDS - 1));
  assign sts.nb_last  = (nb_cnt == NB_DOWN);

endmodule

FILE: src/tppmm_ctrl.sv
module tppmm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  input  tppmm_pkg::sts_t sts,
  output tppmm_pkg::cmd_t cmd
);
  import tppmm_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_INDEX;
      end
      ST_INDEX: state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (sts.op)
          OP_WR_FOUND, OP_WR_OVL: state_next = sts.in_img ? ST_WR_READ : ST_DONE;
          OP_QUERY:               state_next = sts.in_img ? ST_Q_READ : ST_DONE;
          OP_MERGE:               state_next = ST_MG_READ;
          default:                state_next = ST_DONE;
        endcase
      end
      ST_WR_READ:  state_next = ST_WR_WRITE;
      ST_WR_WRITE: state_next = ST_DONE;
      ST_Q_READ:   state_next = ST_Q_CAP;
      ST_Q_CAP: begin
        state_next = sts.nb_last ? ST_DONE : ST_Q_READ;
      end
      ST_MG_READ: state_next = ST_MG_WRITE;
      ST_MG_WRITE: begin
        state_next = sts.cnt_last ? ST_DONE : ST_MG_READ;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INDEX: cmd.calc = 1'b1;
      ST_DISPATCH: begin
        cmd.flag_err = (sts.op != OP_MERGE) && !sts.in_img;
      end
      ST_WR_READ:  cmd.rd_point = 1'b1;
      ST_WR_WRITE: cmd.wr_point = 1'b1;
      ST_Q_READ:   cmd.rd_point = 1'b1;
      ST_Q_CAP: begin
        cmd.cap_nb = 1'b1;
        cmd.nb_inc = 1'b1;
      end
      ST_MG_READ: cmd.rd_sweep = 1'b1;
      ST_MG_WRITE: begin
        cmd.wr_merge = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

endmodule
